// ===== rtl/core/i3ctb_pkg.sv =====
package i3ctb_pkg;

    localparam int unsigned MAX_BUFFER_BYTES = 256;

    localparam int unsigned SIZE_CFG_W = 9;
    localparam int unsigned MAGIC_W    = 8;
    localparam int unsigned DELAY_W    = 32;
    localparam int unsigned ADDR7_W    = 7;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [SIZE_CFG_W-1:0] BUFFER_SIZE_RST = 9'd256;
    localparam logic [MAGIC_W-1:0]    MAGIC_RST       = 8'h00;
    localparam logic [DELAY_W-1:0]    DELAY_RST       = 32'd1000000;
    localparam logic [ADDR7_W-1:0]    TARGET_ADDR_RST = 7'd0;

    typedef enum logic [2:0] {
        FN_STOP    = 3'd0,
        FN_PWRITE  = 3'd1,
        FN_PREAD   = 3'd2,
        FN_CCC_WR  = 3'd3,
        FN_CCC_RD  = 3'd4,
        FN_TICK    = 3'd5,
        FN_OTHER   = 3'd6
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUFFER_SIZE = 2'd0,
        CFG_MAGIC_BYTE  = 2'd1,
        CFG_IBI_DELAY   = 2'd2,
        CFG_TARGET_ADDR = 2'd3
    } cfg_idx_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_CCC = 2'd2;

    localparam logic [7:0] CCC_ENEC    = 8'h00;
    localparam logic [7:0] CCC_DISEC   = 8'h01;
    localparam logic [7:0] CCC_RSTDAA  = 8'h06;
    localparam logic [7:0] CCC_ENTDAA  = 8'h07;
    localparam logic [7:0] CCC_SETAASA = 8'h29;
    localparam logic [7:0] CCC_SETDASA = 8'h87;
    localparam logic [7:0] CCC_GETMWL  = 8'h8B;
    localparam logic [7:0] CCC_GETMRL  = 8'h8C;
    localparam logic [7:0] CCC_GETPID  = 8'h8D;
    localparam logic [7:0] CCC_GETBCR  = 8'h8E;
    localparam logic [7:0] CCC_GETDCR  = 8'h8F;
    localparam logic [7:0] CCC_GETMXDS = 8'h94;
    localparam logic [7:0] CCC_GETCAPS = 8'h95;

    localparam logic [7:0] CAPS_SECOND = 8'h01;

    typedef struct packed {
        logic [7:0]         read_data;
        logic               data_valid;
        logic [1:0]         status;
        logic               ibi_request;
        logic [ADDR7_W-1:0] ibi_address;
        logic               use_ram;
    } result_t;

endpackage

// ===== rtl/core/i3c_target_buffer_device_core.sv =====
// I3C target with a byte buffer, CCC handling and a delayed in-band interrupt.
// The slave stream carries one bus event per transfer: s_tuser holds the event
// code, s_tdata the written byte and the first-byte-of-transfer flag, and
// s_tlast marks the last byte of a bus transfer. Every accepted event produces
// exactly one result on the master stream: read byte, status, IBI request and
// IBI address in m_tdata, and m_tuser set when the read byte is valid.
// The buffer lives in a RAM with a registered read port, which sets the first
// stage; the second stage is the output register. One event is accepted every
// cycle while the output drains. After reset the buffer RAM is cleared one
// entry per cycle, from the first address to the last; s_tready stays low
// during this pass, while configuration writes are taken at any time.
// When m_tready is low the output holds its result and one more result waits
// in the first stage; after that s_tready drops until the receiver catches up.
module i3c_target_buffer_device_core #(
    parameter int unsigned MAX_BUFFER_BYTES = i3ctb_pkg::MAX_BUFFER_BYTES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [i3ctb_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [i3ctb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // write_data[7:0], first_of_transfer[8]
    input  logic [2:0]                       s_tuser,   // func[2:0]
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_data[7:0], status[9:8], ibi_request[10], ibi_address[17:11]
    output logic [23:0]                      m_tdata,
    output logic                             m_tuser    // data_valid
);

    logic               acc;
    logic               busy;
    logic [7:0]         ram_rdata;
    i3ctb_pkg::result_t res;

    logic               s1_valid_reg, s1_valid_next;
    i3ctb_pkg::result_t s1_res_reg;
    logic               s1_adv;

    logic               out_valid_reg, out_valid_next;
    logic [23:0]        out_data_reg;
    logic               out_user_reg;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !busy && (!s1_valid_reg || s1_adv);
    assign acc      = s_tvalid && s_tready;

    i3ctb_ctrl #(
        .MAX_BUFFER_BYTES(MAX_BUFFER_BYTES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata),
        .acc      (acc),
        .func     (s_tuser),
        .wdata    (s_tdata[7:0]),
        .first    (s_tdata[8]),
        .last     (s_tlast),
        .busy     (busy),
        .res      (res),
        .ram_rdata(ram_rdata)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (acc) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_adv) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_res_reg <= res;
        end
        if (s1_adv) begin
            out_data_reg <= {6'b0, s1_res_reg.ibi_address, s1_res_reg.ibi_request,
                             s1_res_reg.status,
                             s1_res_reg.use_ram ? ram_rdata : s1_res_reg.read_data};
            out_user_reg <= s1_res_reg.data_valid;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== rtl/core/i3ctb_ram.sv =====
module i3ctb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/i3ctb_ctrl.sv =====
module i3ctb_ctrl #(
    parameter int unsigned MAX_BUFFER_BYTES = i3ctb_pkg::MAX_BUFFER_BYTES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [i3ctb_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [i3ctb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              acc,
    input  logic [2:0]                        func,
    input  logic [7:0]                        wdata,
    input  logic                              first,
    input  logic                              last,
    output logic                              busy,
    output i3ctb_pkg::result_t                res,
    output logic [7:0]                        ram_rdata
);

    localparam int unsigned ADDR_W = $clog2(MAX_BUFFER_BYTES);
    localparam int unsigned SIZE_W = $clog2(MAX_BUFFER_BYTES + 1);
    localparam logic [15:0] MAX_SIZE = 16'(MAX_BUFFER_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_BUFFER_BYTES - 1);

    logic [i3ctb_pkg::SIZE_CFG_W-1:0] size_cfg_reg;
    logic [i3ctb_pkg::MAGIC_W-1:0]    magic_reg;
    logic [i3ctb_pkg::DELAY_W-1:0]    delay_reg;
    logic [i3ctb_pkg::ADDR7_W-1:0]    taddr_reg;

    logic [SIZE_W-1:0] pos_reg, pos_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic              cmd_valid_reg, cmd_valid_next;
    logic [1:0]        off_reg, off_next;
    logic              ien_reg, ien_next;
    logic [31:0]       cnt_reg, cnt_next;
    logic              armed_reg, armed_next;
    logic              clr_busy_reg, clr_busy_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic [15:0]       size16;
    logic [SIZE_W-1:0] size;
    logic [7:0]        cmd_sel;
    logic [31:0]       cnt_dec;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;

    i3ctb_pkg::func_t fn;

    assign fn      = i3ctb_pkg::func_t'(func);
    assign size16  = (16'(size_cfg_reg) > MAX_SIZE) ? MAX_SIZE : 16'(size_cfg_reg);
    assign size    = size16[SIZE_W-1:0];
    assign cmd_sel = cmd_valid_reg ? cmd_reg : wdata;
    assign cnt_dec = (cnt_reg != 32'd0) ? cnt_reg - 32'd1 : 32'd0;
    assign busy    = clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_cfg_reg <= i3ctb_pkg::BUFFER_SIZE_RST;
            magic_reg    <= i3ctb_pkg::MAGIC_RST;
            delay_reg    <= i3ctb_pkg::DELAY_RST;
            taddr_reg    <= i3ctb_pkg::TARGET_ADDR_RST;
        end else if (cfg_we) begin
            case (i3ctb_pkg::cfg_idx_t'(cfg_addr))
                i3ctb_pkg::CFG_BUFFER_SIZE: size_cfg_reg <= cfg_wdata[i3ctb_pkg::SIZE_CFG_W-1:0];
                i3ctb_pkg::CFG_MAGIC_BYTE:  magic_reg    <= cfg_wdata[i3ctb_pkg::MAGIC_W-1:0];
                i3ctb_pkg::CFG_IBI_DELAY:   delay_reg    <= cfg_wdata[i3ctb_pkg::DELAY_W-1:0];
                i3ctb_pkg::CFG_TARGET_ADDR: taddr_reg    <= cfg_wdata[i3ctb_pkg::ADDR7_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pos_next       = pos_reg;
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg;
        off_next       = off_reg;
        ien_next       = ien_reg;
        cnt_next       = cnt_reg;
        armed_next     = armed_reg;
        clr_busy_next  = clr_busy_reg;
        clr_cnt_next   = clr_cnt_reg;
        res            = '0;
        ram_we         = 1'b0;
        ram_waddr      = clr_cnt_reg;
        ram_wdata      = 8'h00;
        ram_re         = 1'b0;

        if (clr_busy_reg) begin
            ram_we       = 1'b1;
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ADDR) begin
                clr_busy_next = 1'b0;
            end
        end

        if (acc) begin
            case (fn)
                i3ctb_pkg::FN_STOP: begin
                    pos_next       = '0;
                    cmd_next       = 8'h00;
                    cmd_valid_next = 1'b0;
                    off_next       = 2'd0;
                end
                i3ctb_pkg::FN_PWRITE: begin
                    if (magic_reg != 8'h00 && first && last && wdata == magic_reg) begin
                        cnt_next   = (delay_reg == 32'd0) ? 32'd1 : delay_reg;
                        armed_next = 1'b1;
                    end else if (pos_reg >= size) begin
                        res.status = i3ctb_pkg::ST_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = pos_reg[ADDR_W-1:0];
                        ram_wdata = wdata;
                        pos_next  = pos_reg + 1'b1;
                    end
                end
                i3ctb_pkg::FN_PREAD: begin
                    if (pos_reg < size) begin
                        ram_re         = 1'b1;
                        res.use_ram    = 1'b1;
                        res.data_valid = 1'b1;
                        pos_next       = pos_reg + 1'b1;
                    end
                end
                i3ctb_pkg::FN_CCC_WR: begin
                    cmd_valid_next = 1'b1;
                    cmd_next       = cmd_sel;
                    case (cmd_sel)
                        i3ctb_pkg::CCC_ENEC:  ien_next = 1'b1;
                        i3ctb_pkg::CCC_DISEC: ien_next = 1'b0;
                        i3ctb_pkg::CCC_ENTDAA, i3ctb_pkg::CCC_SETAASA,
                        i3ctb_pkg::CCC_RSTDAA, i3ctb_pkg::CCC_SETDASA,
                        i3ctb_pkg::CCC_GETPID, i3ctb_pkg::CCC_GETBCR,
                        i3ctb_pkg::CCC_GETDCR, i3ctb_pkg::CCC_GETMWL,
                        i3ctb_pkg::CCC_GETMRL, i3ctb_pkg::CCC_GETMXDS,
                        i3ctb_pkg::CCC_GETCAPS: ;
                        default: res.status = i3ctb_pkg::ST_BAD_CCC;
                    endcase
                end
                i3ctb_pkg::FN_CCC_RD: begin
                    if (!cmd_valid_reg) begin
                        res.status = i3ctb_pkg::ST_BAD_CCC;
                    end else begin
                        case (cmd_reg)
                            i3ctb_pkg::CCC_GETMXDS, i3ctb_pkg::CCC_GETCAPS,
                            i3ctb_pkg::CCC_GETMWL, i3ctb_pkg::CCC_GETMRL: begin
                                if (off_reg < 2'd2) begin
                                    if (cmd_reg == i3ctb_pkg::CCC_GETMXDS) begin
                                        res.read_data = 8'h00;
                                    end else if (cmd_reg == i3ctb_pkg::CCC_GETCAPS) begin
                                        res.read_data = (off_reg == 2'd0) ? 8'h00
                                                                          : i3ctb_pkg::CAPS_SECOND;
                                    end else begin
                                        res.read_data = (off_reg == 2'd0) ? size16[15:8]
                                                                          : size16[7:0];
                                    end
                                    res.data_valid = 1'b1;
                                    off_next       = off_reg + 2'd1;
                                end
                            end
                            i3ctb_pkg::CCC_ENTDAA, i3ctb_pkg::CCC_GETPID,
                            i3ctb_pkg::CCC_GETBCR, i3ctb_pkg::CCC_GETDCR: ;
                            default: res.status = i3ctb_pkg::ST_BAD_CCC;
                        endcase
                    end
                end
                i3ctb_pkg::FN_TICK: begin
                    if (armed_reg) begin
                        cnt_next = cnt_dec;
                        if (cnt_dec == 32'd0) begin
                            armed_next = 1'b0;
                            if (ien_reg) begin
                                res.ibi_request = 1'b1;
                                res.ibi_address = taddr_reg;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            cmd_reg       <= 8'h00;
            cmd_valid_reg <= 1'b0;
            off_reg       <= 2'd0;
            ien_reg       <= 1'b0;
            cnt_reg       <= 32'd0;
            armed_reg     <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
        end else begin
            pos_reg       <= pos_next;
            cmd_reg       <= cmd_next;
            cmd_valid_reg <= cmd_valid_next;
            off_reg       <= off_next;
            ien_reg       <= ien_next;
            cnt_reg       <= cnt_next;
            armed_reg     <= armed_next;
            clr_busy_reg  <= clr_busy_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    i3ctb_ram #(
        .WIDTH(8),
        .DEPTH(MAX_BUFFER_BYTES)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(pos_reg[ADDR_W-1:0]),
        .rdata(ram_rdata)
    );

endmodule

// ===== rtl/core/i3ctb_checker.sv =====
module i3ctb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result keeps its contents until the receiver takes it.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A result without a data byte carries a zero byte, and a data byte comes with ok status.
    a_data_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser ? (m_tdata[9:8] == i3ctb_pkg::ST_OK) : (m_tdata[7:0] == 8'h00)))
        else $error("read byte and data flag disagree");

    // The interrupt address is shown only with an interrupt request.
    a_ibi_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[10] |-> m_tdata[17:11] == 7'd0)
        else $error("interrupt address without request");

    // The buffer clear after reset keeps the input closed for its first cycle.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input opened before the buffer clear");

endmodule

bind i3c_target_buffer_device_core i3ctb_checker u_i3ctb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
